@@ rtl/arith_expression_tokenizer_core_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ARITH_EXPRESSION_TOKENIZER_CORE_MACROS_SVH
`define ARITH_EXPRESSION_TOKENIZER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AETK_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define AETK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/aetk_pkg.sv @@
// Package with the token codes, widths and character classes of the tokenizer.
`timescale 1ns / 1ps

package aetk_pkg;

   localparam int VALUE_BITS = 31;
   localparam int LINE_BITS = 16;
   localparam int WIDE_BITS = VALUE_BITS + 4;
   localparam int KIND_BITS = 4;
   localparam int CHAR_BITS = 8;
   localparam int PAYLOAD_BITS = VALUE_BITS + 1 + LINE_BITS;
   localparam int DATA_BITS = ((PAYLOAD_BITS + 7) / 8) * 8;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_BITS-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [CHAR_BITS-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_RETURN = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_FORMFEED = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_EOF = 4'd0,
      KIND_PLUS = 4'd1,
      KIND_MINUS = 4'd2,
      KIND_STAR = 4'd3,
      KIND_SLASH = 4'd4,
      KIND_LPAREN = 4'd5,
      KIND_RPAREN = 4'd6,
      KIND_INTLIT = 4'd7,
      KIND_ERROR = 4'd8
   } token_kind_type;

   typedef struct packed {
      logic emit;
      token_kind_type kind;
   } char_class_type;

   typedef struct packed {
      token_kind_type kind;
      logic [VALUE_BITS-1:0] value;
      logic overflow;
      logic [LINE_BITS-1:0] line;
      logic last;
   } token_entry_type;

   function automatic char_class_type classify(input logic [CHAR_BITS-1:0] c);
      char_class_type r;
      r.emit = 1'b1;
      r.kind = KIND_ERROR;
      case (c)
         CHAR_NUL: r.kind = KIND_EOF;
         CHAR_PLUS: r.kind = KIND_PLUS;
         CHAR_MINUS: r.kind = KIND_MINUS;
         CHAR_STAR: r.kind = KIND_STAR;
         CHAR_SLASH: r.kind = KIND_SLASH;
         CHAR_LPAREN: r.kind = KIND_LPAREN;
         CHAR_RPAREN: r.kind = KIND_RPAREN;
         CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_RETURN, CHAR_FORMFEED: r.emit = 1'b0;
         default: r.kind = KIND_ERROR;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/arith_expression_tokenizer_core.sv @@
// Top level of the arithmetic expression tokenizer: lexer state and result queue.
`timescale 1ns / 1ps

// The tokenizer takes one character byte per transfer and can accept a byte in every cycle.
// Each byte is classified and the lexer state (literal accumulator, line counter, halt flag)
// is updated in the cycle of its transfer; its zero, one or two tokens enter a four-entry
// result queue, and req_tready is low only while fewer than two queue slots are free.
// A byte that ends a literal and is itself a token gives two tokens, so the sustained rate is
// one byte per cycle except where the result side must drain two tokens for one byte.
// After an end-of-input or error token every further byte is taken and dropped until reset.
module arith_expression_tokenizer_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [aetk_pkg::CHAR_BITS-1:0] req_tdata,  // char_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // literal_value, literal_overflow, line_number
   output logic [aetk_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic [aetk_pkg::KIND_BITS-1:0] rsp_tuser,  // token_kind
   output logic rsp_tlast                             // last_of_run
);
   import aetk_pkg::*;
   `include "arith_expression_tokenizer_core_macros.svh"

   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   logic in_number_ff, in_number_in;
   logic [VALUE_BITS-1:0] accum_ff, accum_in;
   logic accum_ovf_ff, accum_ovf_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic halted_ff, halted_in;

   token_entry_type fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   logic req_xfer, rsp_xfer, active;
   logic digit;
   logic [WIDE_BITS-1:0] prod;
   logic prod_ovf;
   char_class_type cls;
   logic emit_lit, emit_tok, push0, push1;
   token_entry_type res_lit, res_tok, res0, res1;
   token_entry_type head;

   assign req_tready = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign req_xfer = req_tvalid && req_tready;
   assign active = req_xfer && !halted_ff;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      cls = classify(req_tdata);
      prod = (WIDE_BITS'(accum_ff) << 3) + (WIDE_BITS'(accum_ff) << 1)
           + WIDE_BITS'(req_tdata[3:0]);
      prod_ovf = accum_ovf_ff || (prod[WIDE_BITS-1:VALUE_BITS] != '0);

      line_in = line_ff;
      if (active && (req_tdata == CHAR_NEWLINE) && (line_ff != LINE_MAX)) begin
         line_in = line_ff + LINE_BITS'(1);
      end

      emit_lit = active && in_number_ff && !digit;
      emit_tok = active && !digit && cls.emit;

      in_number_in = in_number_ff;
      accum_in = accum_ff;
      accum_ovf_in = accum_ovf_ff;
      halted_in = halted_ff;
      if (active) begin
         if (digit) begin
            in_number_in = 1'b1;
            if (in_number_ff) begin
               accum_ovf_in = prod_ovf;
               accum_in = prod_ovf ? VALUE_MAX : prod[VALUE_BITS-1:0];
            end else begin
               accum_ovf_in = 1'b0;
               accum_in = VALUE_BITS'(req_tdata[3:0]);
            end
         end else begin
            in_number_in = 1'b0;
            accum_in = '0;
            accum_ovf_in = 1'b0;
            if (cls.emit && ((cls.kind == KIND_EOF) || (cls.kind == KIND_ERROR))) begin
               halted_in = 1'b1;
            end
         end
      end

      res_lit.kind = KIND_INTLIT;
      res_lit.value = accum_ff;
      res_lit.overflow = accum_ovf_ff;
      res_lit.line = line_in;
      res_lit.last = !emit_tok;
      res_tok.kind = cls.kind;
      res_tok.value = '0;
      res_tok.overflow = 1'b0;
      res_tok.line = line_in;
      res_tok.last = 1'b1;

      push0 = emit_lit || emit_tok;
      push1 = emit_lit && emit_tok;
      res0 = emit_lit ? res_lit : res_tok;
      res1 = res_tok;

      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'({1'b0, push0} + {1'b0, push1});
      rd_ptr_in = rsp_xfer ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff + FIFO_CNT_BITS'(push0) + FIFO_CNT_BITS'(push1)
               - FIFO_CNT_BITS'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_number_ff <= 1'b0;
         accum_ff <= '0;
         accum_ovf_ff <= 1'b0;
         line_ff <= LINE_BITS'(1);
         halted_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         in_number_ff <= in_number_in;
         accum_ff <= accum_in;
         accum_ovf_ff <= accum_ovf_in;
         line_ff <= line_in;
         halted_ff <= halted_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_BITS'(1)] <= res1;
      end
   end

   assign head = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata = DATA_BITS'({head.line, head.overflow, head.value});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   `AETK_ASSERT_ALWAYS(a_count_bound, count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue count exceeds depth")
   `AETK_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff, "halt flag cleared without reset")
   `AETK_ASSERT_ALWAYS(a_number_not_halted, !(in_number_ff && halted_ff), "literal open while halted")
   `AETK_ASSERT_ALWAYS(a_idle_accum_clear, in_number_ff || (accum_ff == '0 && !accum_ovf_ff), "accumulator not cleared outside a literal")
   `AETK_ASSERT_NEXT(a_halted_no_push, req_xfer && halted_ff, count_ff <= $past(count_ff), "token queued while halted")
   `AETK_ASSERT_ALWAYS(a_plain_token_zero, !rsp_tvalid || head.kind == KIND_INTLIT || (head.value == '0 && !head.overflow), "non-literal token carries a value")

endmodule
